>>> hw/rtl/parking_gate_controller_macros.svh
// ----------------------------------------------------------------------------
// parking gate controller assertion macros
// shared property wrappers clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef PARKING_GATE_CONTROLLER_MACROS_SVH
`define PARKING_GATE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// types, codes and helpers shared by the parking gate controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pgc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CAP_W           = 10;
  localparam int unsigned OCC_W           = 10;
  localparam int unsigned PH_W            = 2;
  localparam int unsigned VIEW_W          = 2;
  localparam int unsigned CMD_W           = 2;
  localparam int unsigned DIG_W           = 4;
  localparam int unsigned SHOW_W          = 10;

  localparam logic [OCC_W-1:0]  OCC_MAX   = 10'd1023;
  localparam logic [SHOW_W-1:0] SHOW_MAX  = 10'd999;
  localparam logic [CAP_W-1:0]  CAP_RESET = 10'd100;

  // barrier phases
  localparam logic [PH_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PH_W-1:0] PH_ARMED = 2'd1;
  localparam logic [PH_W-1:0] PH_OPEN  = 2'd2;

  // event kinds
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICKET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SENSE  = 2'd2;

  // display selections
  localparam logic [VIEW_W-1:0] VIEW_ENTRIES = 2'd0;
  localparam logic [VIEW_W-1:0] VIEW_EXITS   = 2'd1;
  localparam logic [VIEW_W-1:0] VIEW_OCC     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             entry_car_sensor;
    logic             exit_car_sensor;
    logic             ticket_request;
    logic             mode_button;
    logic             entry_passed_sensor;
    logic             ticket_inserted;
    logic             exit_passed_sensor;
  } in_word_t;

  typedef struct packed {
    logic              entry_gate_open;
    logic              exit_gate_open;
    logic              full_lamp;
    logic [VIEW_W-1:0] display_mode;
    logic [DIG_W-1:0]  digit_hundreds;
    logic [DIG_W-1:0]  digit_tens;
    logic [DIG_W-1:0]  digit_units;
  } out_word_t;

  typedef struct packed {
    logic              entry_open;
    logic              exit_open;
    logic              full;
    logic [VIEW_W-1:0] view;
    logic [SHOW_W-1:0] shown;
  } status_t;

  typedef struct packed {
    logic [DIG_W-1:0] hundreds;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] units;
  } bcd_t;

  // value must be at most 999
  function automatic bcd_t to_bcd(input logic [SHOW_W-1:0] value);
    logic [DIG_W-1:0]  h;
    logic [DIG_W-1:0]  t;
    logic [SHOW_W-1:0] rem_h;
    logic [6:0]        rem_t;
    bcd_t              r;
    h = '0;
    for (int k = 1; k <= 9; k++) begin
      if (value >= SHOW_W'(k * 100)) begin
        h = h + 4'd1;
      end
    end
    rem_h = value - SHOW_W'(32'(h) * 100);
    rem_t = rem_h[6:0];
    t = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_t >= 7'(k * 10)) begin
        t = t + 4'd1;
      end
    end
    r.hundreds = h;
    r.tens     = t;
    r.units    = DIG_W'(rem_t - 7'(32'(t) * 10));
    return r;
  endfunction

endpackage

>>> hw/rtl/pgc_state.sv
// ----------------------------------------------------------------------------
// pgc_state
// barrier phases, counters, occupancy, full flag and display selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "parking_gate_controller_macros.svh"

module pgc_state
  import pgc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             adv_i,
  input  in_word_t         word_i,
  output status_t          status_o
);

  logic [CAP_W-1:0]       cap_q;
  logic [PH_W-1:0]        entry_q, entry_d;
  logic [PH_W-1:0]        exit_q, exit_d;
  logic [COUNT_WIDTH-1:0] ent_q, ent_d;
  logic [COUNT_WIDTH-1:0] exi_q, exi_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic                   full_q, full_d;
  logic [VIEW_W-1:0]      view_q, view_d;
  logic [COUNT_WIDTH-1:0] shown_cnt;

  always_comb begin
    logic park_full;
    logic halt;
    entry_d   = entry_q;
    exit_d    = exit_q;
    ent_d     = ent_q;
    exi_d     = exi_q;
    occ_d     = occ_q;
    full_d    = full_q;
    view_d    = view_q;
    halt      = 1'b0;
    park_full = (occ_q >= cap_q);
    unique case (word_i.command)
      CMD_TICK: begin
        if (word_i.entry_car_sensor) begin
          if (park_full) begin
            halt = 1'b1;
          end else if (entry_q != PH_OPEN) begin
            entry_d = PH_ARMED;
          end
        end
        if (!halt && word_i.exit_car_sensor && occ_q != '0 && exit_q != PH_OPEN) begin
          exit_d = PH_ARMED;
        end
      end
      CMD_TICKET: begin
        if (word_i.ticket_request && !park_full && entry_q == PH_ARMED) begin
          entry_d = PH_OPEN;
        end
      end
      CMD_SENSE: begin
        if (word_i.mode_button) begin
          view_d = (view_q >= VIEW_OCC) ? VIEW_ENTRIES : view_q + 2'd1;
        end
        if (word_i.entry_passed_sensor && entry_q == PH_OPEN) begin
          entry_d = PH_IDLE;
          ent_d   = ent_q + 1'b1;
          if (occ_q < OCC_MAX) begin
            occ_d = occ_q + 1'b1;
          end
          if (occ_d >= cap_q) begin
            full_d = 1'b1;
          end
        end
        if (word_i.ticket_inserted) begin
          if (occ_d == '0) begin
            halt = 1'b1;
          end else if (exit_q == PH_ARMED) begin
            exit_d = PH_OPEN;
          end
        end
        if (!halt && word_i.exit_passed_sensor && exit_d == PH_OPEN) begin
          exit_d = PH_IDLE;
          full_d = 1'b0;
          exi_d  = exi_q + 1'b1;
          if (occ_d != '0) begin
            occ_d = occ_d - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= PH_IDLE;
      exit_q  <= PH_IDLE;
      ent_q   <= '0;
      exi_q   <= '0;
      occ_q   <= '0;
      full_q  <= 1'b0;
      view_q  <= VIEW_OCC;
    end else if (adv_i) begin
      entry_q <= entry_d;
      exit_q  <= exit_d;
      ent_q   <= ent_d;
      exi_q   <= exi_d;
      occ_q   <= occ_d;
      full_q  <= full_d;
      view_q  <= view_d;
    end
  end

  // shown value follows the state after this word
  always_comb begin
    if (view_d == VIEW_ENTRIES) begin
      shown_cnt = ent_d;
    end else if (view_d == VIEW_EXITS) begin
      shown_cnt = exi_d;
    end else begin
      shown_cnt = COUNT_WIDTH'(occ_d);
    end
  end

  assign status_o.entry_open = (entry_d == PH_OPEN);
  assign status_o.exit_open  = (exit_d == PH_OPEN);
  assign status_o.full       = full_d;
  assign status_o.view       = view_d;
  assign status_o.shown      = (shown_cnt > COUNT_WIDTH'(SHOW_MAX)) ? SHOW_MAX
                                                                    : shown_cnt[SHOW_W-1:0];

  `PGC_ASSERT_NEXT(a_entry_armed_first, entry_q == PH_IDLE, entry_q != PH_OPEN, "entry opened unarmed")
  `PGC_ASSERT_NEXT(a_counts_hold, !adv_i, $stable(ent_q) && $stable(exi_q) && $stable(occ_q), "counts moved without a word")
  `PGC_ASSERT_NEXT(a_full_rise, !full_q && !(adv_i && word_i.command == CMD_SENSE), !full_q, "full set outside a sensor word")

endmodule

>>> hw/rtl/pgc_disp.sv
// ----------------------------------------------------------------------------
// pgc_disp
// forms the result word: gate drives, lamp, mode and three decimal digits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pgc_disp
  import pgc_pkg::*;
(
  input  status_t   status_i,
  output out_word_t word_o
);

  bcd_t digits;

  assign digits = to_bcd(status_i.shown);

  assign word_o.entry_gate_open = status_i.entry_open;
  assign word_o.exit_gate_open  = status_i.exit_open;
  assign word_o.full_lamp       = status_i.full;
  assign word_o.display_mode    = status_i.view;
  assign word_o.digit_hundreds  = digits.hundreds;
  assign word_o.digit_tens      = digits.tens;
  assign word_o.digit_units     = digits.units;

endmodule

>>> hw/rtl/parking_gate_controller.sv
// ----------------------------------------------------------------------------
// parking_gate_controller
// entry and exit barrier control with counters, full lamp and count display
//
//   port group     dir  handshake              payload
//   in_*           in   in_valid_i/in_stall_o  in_word_i   (in_word_t)
//   out_*          out  out_valid_o/out_stall_i out_word_o (out_word_t)
//   cfg_*          in   cfg_we_i               cfg_wdata_i (capacity)
//
// one word per cycle sustained while the output is not stalled; a word is
// taken into the input register, then state update and digit conversion
// write its result into the result register; reset clears phases, counters
// and full flag, selects occupancy view; capacity returns to 100 spaces
// a stall on the output holds the result register; the input register
// keeps taking words as long as the result register can move
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parking_gate_controller
  import pgc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_word_o
);

  in_word_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_word_t out_q;
  logic      out_vld_q, out_vld_d;
  logic      move;
  logic      take;
  status_t   status;
  out_word_t res_word;

  assign move       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !move;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (move) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (move) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_word_i;
    end
    if (move) begin
      out_q <= res_word;
    end
  end

  pgc_state #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .adv_i      (move),
    .word_i     (in_q),
    .status_o   (status)
  );

  pgc_disp u_disp (
    .status_i(status),
    .word_o  (res_word)
  );

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

>>> dv/parking_gate_controller_tb.sv
// ----------------------------------------------------------------------------
// parking_gate_controller_tb
// self-checking bench: a directed script walks gate, counter, lamp and display
// cases, then random car traffic runs under several capacities with random
// gaps on both sides and one long output hold. every result word is compared
// field by field with a scripted expectation or with a behavioral model of the
// controller kept in the bench
`timescale 1ns / 1ps

module parking_gate_controller_tb;
  import pgc_pkg::*;

  localparam int unsigned LIMIT      = 1500000;

  // unused event kind
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  // sensor bits in word order
  localparam logic [6:0] S_ENTRY_CAR  = 7'b1000000;
  localparam logic [6:0] S_EXIT_CAR   = 7'b0100000;
  localparam logic [6:0] S_TICKET     = 7'b0010000;
  localparam logic [6:0] S_MODE       = 7'b0001000;
  localparam logic [6:0] S_ENTRY_PASS = 7'b0000100;
  localparam logic [6:0] S_TICKET_IN  = 7'b0000010;
  localparam logic [6:0] S_EXIT_PASS  = 7'b0000001;
  localparam logic [6:0] S_ALL        = 7'b1111111;

  typedef struct {
    bit               is_cap;
    logic [CAP_W-1:0] cap;
    in_word_t         word;
    bit               known;
    out_word_t        want;
  } script_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_word_t        out_word_o;

  script_row_t script[$];
  script_row_t car_events_q[$];
  out_word_t   panel_q[$];

  // model of the controller
  logic [CAP_W-1:0]           cap_reg = CAP_RESET;
  logic [PH_W-1:0]            entry_ph;
  logic [PH_W-1:0]            exit_ph;
  logic [COUNT_WIDTH_DEF-1:0] entries_cnt;
  logic [COUNT_WIDTH_DEF-1:0] exits_cnt;
  logic [OCC_W-1:0]           occ_cnt;
  logic                       full_lit;
  logic [VIEW_W-1:0]          view_sel;

  int  faults    = 0;
  int  cycles    = 0;
  int  gap_left  = 0;
  int  hold_left = 0;
  bit  calm_send = 1'b0;
  bit  calm_recv = 1'b0;
  bit  squeeze   = 1'b0;
  bit  squeezed  = 1'b0;

  parking_gate_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_word_t ev(input logic [CMD_W-1:0] cmd, input logic [6:0] bits);
    return in_word_t'({cmd, bits});
  endfunction

  function automatic out_word_t panel(input int eo, input int xo, input int lamp,
                                      input logic [VIEW_W-1:0] view,
                                      input int h, input int t, input int u);
    return out_word_t'({1'(eo), 1'(xo), 1'(lamp), view,
                        DIG_W'(h), DIG_W'(t), DIG_W'(u)});
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void apply_event(input in_word_t w);
    case (w.command)
      CMD_TICK: begin
        if (w.entry_car_sensor) begin
          if (occ_cnt >= cap_reg) return;
          if (entry_ph != PH_OPEN) entry_ph = PH_ARMED;
        end
        if (w.exit_car_sensor) begin
          if (occ_cnt == '0) return;
          if (exit_ph != PH_OPEN) exit_ph = PH_ARMED;
        end
      end
      CMD_TICKET: begin
        if (w.ticket_request && occ_cnt < cap_reg && entry_ph == PH_ARMED) entry_ph = PH_OPEN;
      end
      CMD_SENSE: begin
        if (w.mode_button) view_sel = (view_sel >= VIEW_OCC) ? VIEW_ENTRIES : view_sel + 1'b1;
        if (w.entry_passed_sensor && entry_ph == PH_OPEN) begin
          entry_ph    = PH_IDLE;
          entries_cnt = entries_cnt + 1'b1;
          if (occ_cnt != OCC_MAX) occ_cnt = occ_cnt + 1'b1;
          if (occ_cnt >= cap_reg) full_lit = 1'b1;
        end
        if (w.ticket_inserted) begin
          if (occ_cnt == '0) return;
          if (exit_ph == PH_ARMED) exit_ph = PH_OPEN;
        end
        if (w.exit_passed_sensor && exit_ph == PH_OPEN) begin
          exit_ph   = PH_IDLE;
          full_lit  = 1'b0;
          exits_cnt = exits_cnt + 1'b1;
          if (occ_cnt != '0) occ_cnt = occ_cnt - 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic out_word_t advance_gates(input in_word_t w);
    int        shown;
    out_word_t r;
    apply_event(w);
    case (view_sel)
      VIEW_ENTRIES: shown = int'(entries_cnt);
      VIEW_EXITS:   shown = int'(exits_cnt);
      default:      shown = int'(occ_cnt);
    endcase
    if (shown > 999) shown = 999;
    r.entry_gate_open = (entry_ph == PH_OPEN);
    r.exit_gate_open  = (exit_ph == PH_OPEN);
    r.full_lamp       = full_lit;
    r.display_mode    = view_sel;
    r.digit_hundreds  = DIG_W'(shown / 100);
    r.digit_tens      = DIG_W'((shown / 10) % 10);
    r.digit_units     = DIG_W'(shown % 10);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= 10) $display("mismatch %s: expected %0d got %0d", name, want, got);
    end
  endtask

  task automatic check_panel(input out_word_t got);
    out_word_t want;
    if (panel_q.size() == 0) begin
      faults++;
      if (faults <= 10) $display("unexpected word %p", got);
      return;
    end
    want = panel_q.pop_front();
    check_field("entry_gate_open", 4'(want.entry_gate_open), 4'(got.entry_gate_open));
    check_field("exit_gate_open", 4'(want.exit_gate_open), 4'(got.exit_gate_open));
    check_field("full_lamp", 4'(want.full_lamp), 4'(got.full_lamp));
    check_field("display_mode", 4'(want.display_mode), 4'(got.display_mode));
    check_field("digit_hundreds", want.digit_hundreds, got.digit_hundreds);
    check_field("digit_tens", want.digit_tens, got.digit_tens);
    check_field("digit_units", want.digit_units, got.digit_units);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      gap_left    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        out_word_t pred;
        pred = advance_gates(car_events_q[0].word);
        panel_q.push_back(car_events_q[0].known ? car_events_q[0].want : pred);
        void'(car_events_q.pop_front());
        if (calm_send || $urandom_range(0, 99) < 55) gap_left = 0;
        else gap_left = idle_len();
      end
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (car_events_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_word_i  <= car_events_q[0].word;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left    = 0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (squeeze && !squeezed) begin
      squeezed     = 1'b1;
      hold_left    = 299;
      out_stall_i <= 1'b1;
    end else if (calm_recv) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      hold_left    = idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_panel(out_word_o);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_word(input in_word_t w);
    script_row_t row;
    row = '{is_cap: 1'b0, cap: '0, word: w, known: 1'b0, want: '0};
    script.push_back(row);
  endtask

  task automatic add_known(input in_word_t w, input out_word_t o);
    script_row_t row;
    row = '{is_cap: 1'b0, cap: '0, word: w, known: 1'b1, want: o};
    script.push_back(row);
  endtask

  task automatic add_cap(input logic [CAP_W-1:0] v);
    script_row_t row;
    row = '{is_cap: 1'b1, cap: v, word: '0, known: 1'b0, want: '0};
    script.push_back(row);
  endtask

  task automatic queue_word(input in_word_t w);
    script_row_t row;
    row = '{is_cap: 1'b0, cap: '0, word: w, known: 1'b0, want: '0};
    car_events_q.push_back(row);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (car_events_q.size() != 0 || in_valid_i || panel_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_reg      = v;
  endtask

  task automatic fill_random(input int n);
    int made;
    int pick;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        queue_word(ev(CMD_W'($urandom_range(0, 3)), 7'($urandom_range(0, 127))));
        made++;
      end else if (pick <= 5) begin
        queue_word(ev(CMD_TICK, S_ENTRY_CAR | (($urandom_range(0, 3) == 0) ? S_EXIT_CAR : 7'd0)));
        if ($urandom_range(0, 5) != 0)
          queue_word(ev(CMD_TICKET, S_TICKET | 7'($urandom_range(0, 127))));
        queue_word(ev(CMD_SENSE, S_ENTRY_PASS | (($urandom_range(0, 5) == 0) ? S_MODE : 7'd0)));
        made += 3;
      end else if (pick <= 8) begin
        queue_word(ev(CMD_TICK, S_EXIT_CAR));
        if ($urandom_range(0, 1) == 1) begin
          queue_word(ev(CMD_SENSE, S_TICKET_IN | S_EXIT_PASS));
        end else begin
          queue_word(ev(CMD_SENSE, S_TICKET_IN));
          queue_word(ev(CMD_SENSE, S_EXIT_PASS));
        end
        made += 3;
      end else begin
        queue_word(ev(CMD_SENSE, S_MODE));
        made++;
      end
    end
  endtask

  initial begin
    int caps [6];

    caps        = '{2, 1023, 999, 4, 1, 0};
    entry_ph    = PH_IDLE;
    exit_ph     = PH_IDLE;
    entries_cnt = '0;
    exits_cnt   = '0;
    occ_cnt     = '0;
    full_lit    = 1'b0;
    view_sel    = VIEW_OCC;

    // capacity 100 out of reset
    add_known(ev(CMD_SPARE, S_ALL), panel(0, 0, 0, VIEW_OCC, 0, 0, 0));
    add_known(ev(CMD_TICK, 7'd0), panel(0, 0, 0, VIEW_OCC, 0, 0, 0));
    add_known(ev(CMD_TICK, S_ENTRY_CAR | S_EXIT_CAR), panel(0, 0, 0, VIEW_OCC, 0, 0, 0));
    add_known(ev(CMD_TICKET, S_TICKET), panel(1, 0, 0, VIEW_OCC, 0, 0, 0));
    add_known(ev(CMD_SENSE, S_ENTRY_PASS), panel(0, 0, 0, VIEW_OCC, 0, 0, 1));
    add_word(ev(CMD_SENSE, S_TICKET_IN | S_EXIT_PASS));
    add_word(ev(CMD_TICK, S_EXIT_CAR));
    add_known(ev(CMD_SENSE, S_TICKET_IN), panel(0, 1, 0, VIEW_OCC, 0, 0, 1));
    add_known(ev(CMD_SENSE, S_EXIT_PASS), panel(0, 0, 0, VIEW_OCC, 0, 0, 0));
    add_known(ev(CMD_SENSE, S_MODE), panel(0, 0, 0, VIEW_ENTRIES, 0, 0, 1));
    add_known(ev(CMD_SENSE, S_MODE), panel(0, 0, 0, VIEW_EXITS, 0, 0, 1));
    add_known(ev(CMD_SENSE, S_MODE), panel(0, 0, 0, VIEW_OCC, 0, 0, 0));
    // empty park blocks exit arming and ticket reading
    add_word(ev(CMD_TICK, S_EXIT_CAR));
    add_word(ev(CMD_SENSE, S_TICKET_IN));
    add_word(ev(CMD_TICKET, S_ALL & ~S_TICKET));
    add_word(ev(CMD_SENSE, S_ALL));
    // one space
    add_cap(10'd1);
    add_word(ev(CMD_TICK, S_ENTRY_CAR));
    add_word(ev(CMD_TICKET, S_TICKET));
    add_word(ev(CMD_SENSE, S_ENTRY_PASS));
    add_word(ev(CMD_TICK, S_ENTRY_CAR | S_EXIT_CAR));
    add_word(ev(CMD_TICKET, S_TICKET));
    add_word(ev(CMD_TICK, S_EXIT_CAR));
    add_word(ev(CMD_SENSE, S_TICKET_IN | S_EXIT_PASS));
    // no spaces, always full
    add_cap(10'd0);
    add_word(ev(CMD_TICK, S_ENTRY_CAR | S_EXIT_CAR));
    add_word(ev(CMD_TICKET, S_TICKET));
    add_word(ev(CMD_SENSE, S_ENTRY_PASS));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cap) begin
        settle();
        set_capacity(script[i].cap);
      end else begin
        car_events_q.push_back(script[i]);
      end
    end
    settle();

    for (int p = 0; p < 7; p++) begin
      calm_send = (p == 2) || (p == 4);
      calm_recv = (p == 2);
      squeeze   = (p == 4);
      set_capacity((p < 6) ? CAP_W'(caps[p]) : CAP_W'($urandom_range(1, 999)));
      fill_random(54);
      settle();
    end
    repeat (8) @(posedge clk_i);

    if (panel_q.size() != 0) faults++;
    if (faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pgc_pkg.sv
hw/rtl/pgc_state.sv
hw/rtl/pgc_disp.sv
hw/rtl/parking_gate_controller.sv
dv/parking_gate_controller_tb.sv
